FILE: src/sfr_pkg.sv
package sfr_pkg;

   localparam logic [7:0] HEAD_FIRST  = 8'hFA;
   localparam logic [7:0] HEAD_SECOND = 8'hFB;
   localparam logic [7:0] TAIL_FIRST  = 8'hFC;
   localparam logic [7:0] TAIL_SECOND = 8'hFD;

   localparam logic [7:0] MIN_LENGTH  = 8'd2;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_HEAD = 3'd1;
   localparam logic [2:0] ST_TAIL = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_LEN  = 3'd4;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] command;
      logic [7:0] payload_index;
      logic [7:0] payload_byte;
      logic [2:0] frame_status;
      logic       is_last;
   } sfr_result_type;

endpackage

FILE: src/sensor_frame_receiver_top.sv
// Sensor frame receiver.
// req_* carries received bytes, one per item. Frames are
//   FA FB LEN CMD DATA[LEN-2] SUM FC FD
// with SUM the 8-bit wrapping sum of CMD and DATA. While hunting, bytes other
// than FA are dropped. Each data byte leaves on rsp_* as a payload item
// (tuser 0) with its index; the last tail byte gives one report (tuser 1,
// tlast 1) with the command and status: ok, head, tail, checksum or length.
// A length byte below 2 reports at once. After an ok report the next byte is
// taken as a head byte; after any error the block hunts again.
// Throughput: one byte per cycle while req_tready is high. A result is
// registered into the output register, or into the skid entry when the
// output is stalled, together with the frame state update for its byte.
// A two-entry output buffer (output register plus skid) lets input continue
// while one result waits; req_tready drops only when both entries are full,
// and items are never dropped while the receiver stalls.
// Reset (synchronous) empties the buffer and returns the block to hunting.
module sensor_frame_receiver_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] command, [15:8] payload_index, [23:16] payload_byte,
   // [26:24] frame_status, [31:27] zero
   output logic [sfr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,  // [0] item_kind
   output logic                            rsp_tlast   // is_last
);
   import sfr_pkg::*;

   logic           accept;
   logic           rslt_valid;
   sfr_result_type rslt;
   logic           push;
   logic           pop;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   sfr_result_type out_ff, out_in;
   sfr_result_type skid_ff, skid_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   sfr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_byte    (req_tdata),
      .rslt_valid (rslt_valid),
      .rslt       (rslt)
   );

   assign push = rslt_valid;
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop && skid_valid_ff) begin
         // no push possible here: input is held off while skid is full
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else if (pop || !out_valid_ff) begin
         out_valid_in = push;
         out_in       = rslt;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = rslt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 27){1'b0}}, out_ff.frame_status,
                        out_ff.payload_byte, out_ff.payload_index, out_ff.command};
   assign rsp_tuser  = out_ff.item_kind;
   assign rsp_tlast  = out_ff.is_last;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff)
      else $error("stalled item lost from output register");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved to output register");

endmodule

FILE: src/sfr_deframer.sv
module sfr_deframer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   output logic                   rslt_valid,
   output sfr_pkg::sfr_result_type rslt
);
   import sfr_pkg::*;

   localparam logic [2:0] PH_HEAD0 = 3'd0;
   localparam logic [2:0] PH_HEAD1 = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_CMD   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_SUM   = 3'd5;
   localparam logic [2:0] PH_TAIL0 = 3'd6;
   localparam logic [2:0] PH_TAIL1 = 3'd7;

   logic       synced_ff, synced_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] received_sum_ff, received_sum_in;
   logic [7:0] command_ff, command_in;
   logic       head_ok_ff, head_ok_in;
   logic       tail_ok_ff, tail_ok_in;

   always_comb begin
      synced_in       = synced_ff;
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      byte_count_in   = byte_count_ff;
      running_sum_in  = running_sum_ff;
      received_sum_in = received_sum_ff;
      command_in      = command_ff;
      head_ok_in      = head_ok_ff;
      tail_ok_in      = tail_ok_ff;
      rslt_valid      = 1'b0;
      rslt            = '0;
      if (in_valid) begin
         unique case (phase_ff)
            PH_HEAD0: begin
               // while hunting, anything but the first head byte is dropped
               if (synced_ff || in_byte == HEAD_FIRST) begin
                  synced_in  = 1'b1;
                  head_ok_in = (in_byte == HEAD_FIRST);
                  phase_in   = PH_HEAD1;
               end
            end
            PH_HEAD1: begin
               head_ok_in = head_ok_ff && (in_byte == HEAD_SECOND);
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               frame_length_in = in_byte;
               if (in_byte < MIN_LENGTH) begin
                  rslt_valid        = 1'b1;
                  rslt.item_kind    = KIND_REPORT;
                  rslt.frame_status = head_ok_ff ? ST_LEN : ST_HEAD;
                  rslt.is_last      = 1'b1;
                  synced_in         = 1'b0;
                  phase_in          = PH_HEAD0;
               end else begin
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               command_in     = in_byte;
               running_sum_in = in_byte;
               byte_count_in  = '0;
               phase_in       = (frame_length_ff == MIN_LENGTH) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               rslt_valid         = 1'b1;
               rslt.item_kind     = KIND_DATA;
               rslt.command       = command_ff;
               rslt.payload_index = byte_count_ff;
               rslt.payload_byte  = in_byte;
               rslt.frame_status  = ST_OK;
               running_sum_in     = running_sum_ff + in_byte;
               byte_count_in      = byte_count_ff + 8'd1;
               if (byte_count_in >= frame_length_ff - MIN_LENGTH) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               received_sum_in = in_byte;
               phase_in        = PH_TAIL0;
            end
            PH_TAIL0: begin
               tail_ok_in = (in_byte == TAIL_FIRST);
               phase_in   = PH_TAIL1;
            end
            PH_TAIL1: begin
               tail_ok_in     = tail_ok_ff && (in_byte == TAIL_SECOND);
               rslt_valid     = 1'b1;
               rslt.item_kind = KIND_REPORT;
               rslt.command   = command_ff;
               rslt.is_last   = 1'b1;
               if (!head_ok_ff) begin
                  rslt.frame_status = ST_HEAD;
               end else if (!tail_ok_in) begin
                  rslt.frame_status = ST_TAIL;
               end else if (received_sum_ff != running_sum_ff) begin
                  rslt.frame_status = ST_SUM;
               end else begin
                  rslt.frame_status = ST_OK;
               end
               // only a clean frame lets the next one start without hunting
               synced_in = (rslt.frame_status == ST_OK);
               phase_in  = PH_HEAD0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff       <= 1'b0;
         phase_ff        <= PH_HEAD0;
         frame_length_ff <= '0;
         byte_count_ff   <= '0;
         running_sum_ff  <= '0;
         received_sum_ff <= '0;
         command_ff      <= '0;
         head_ok_ff      <= 1'b0;
         tail_ok_ff      <= 1'b0;
      end else begin
         synced_ff       <= synced_in;
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         byte_count_ff   <= byte_count_in;
         running_sum_ff  <= running_sum_in;
         received_sum_ff <= received_sum_in;
         command_ff      <= command_in;
         head_ok_ff      <= head_ok_in;
         tail_ok_ff      <= tail_ok_in;
      end
   end

   a_report_rehunts: assert property (@(posedge clock) disable iff (reset)
      rslt_valid && rslt.is_last |=> phase_ff == PH_HEAD0)
      else $error("phase did not return to first head byte after a report");

   a_error_clears_sync: assert property (@(posedge clock) disable iff (reset)
      rslt_valid && rslt.is_last && rslt.frame_status != ST_OK |=> !synced_ff)
      else $error("sync kept after a failed frame");

   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      rslt_valid && rslt.item_kind == KIND_DATA
         |-> byte_count_ff < frame_length_ff - MIN_LENGTH)
      else $error("payload index beyond frame length");

endmodule
